FILE: design/hmf_pkg.sv
// hmf_pkg: types, character constants and text-match helpers for the http message framer
// no dependencies; imported by hmf_len_acc and http_message_framer_core
package hmf_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_BODY    = 3'd2,
        PH_CSIZE   = 3'd3,
        PH_CDATA   = 3'd4,
        PH_CEND    = 3'd5,
        PH_TRAILER = 3'd6
    } t_phase;

    localparam logic [2:0] SEC_HEADER  = 3'd0;
    localparam logic [2:0] SEC_BLANK   = 3'd1;
    localparam logic [2:0] SEC_BODY    = 3'd2;
    localparam logic [2:0] SEC_CSIZE   = 3'd3;
    localparam logic [2:0] SEC_CDATA   = 3'd4;
    localparam logic [2:0] SEC_CEND    = 3'd5;
    localparam logic [2:0] SEC_TRAILER = 3'd6;

    // number parser states
    localparam logic [2:0] NP_IDLE   = 3'd0;
    localparam logic [2:0] NP_ZERO   = 3'd1;  // decimal: in digits
    localparam logic [2:0] NP_PFX    = 3'd2;  // hex: after 0x; decimal: done
    localparam logic [2:0] NP_DIGITS = 3'd3;
    localparam logic [2:0] NP_END    = 3'd4;
    localparam logic [2:0] NP_BAD    = 3'd5;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LC    = 8'h63;

    localparam int KEY_CHARS = 17;
    localparam logic [8*KEY_CHARS-1:0] KEY_PROXY = "proxy-connection ";
    localparam logic [8*KEY_CHARS-1:0] KEY_CONN  = "connection       ";
    localparam logic [8*KEY_CHARS-1:0] KEY_CLEN  = "content-length   ";
    localparam logic [8*KEY_CHARS-1:0] KEY_TENC  = "transfer-encoding";
    localparam logic [4:0] LEN_PROXY = 5'd16;
    localparam logic [4:0] LEN_CONN  = 5'd10;
    localparam logic [4:0] LEN_CLEN  = 5'd14;
    localparam logic [4:0] LEN_TENC  = 5'd17;

    localparam logic [8*12-1:0] KA_TEXT = {"keep-alive", CH_CR, CH_LF};
    localparam logic [3:0]      KA_LEN  = 4'd12;
    localparam logic [8*7-1:0]  CK_TEXT = "chunked";
    localparam logic [2:0]      CK_LEN  = 3'd7;

    typedef struct packed {
        logic [3:0] cand;
        logic [4:0] pos;
    } t_key;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    // 4-bit digit value, bit 4 set when not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) hex_val = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            hex_val = {1'b0, c[3:0] + 4'd9};
        else hex_val = 5'h10;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic key_hit(input logic [8*KEY_CHARS-1:0] key,
                                     input logic [4:0] len, input logic [4:0] pos,
                                     input logic [7:0] c);
        logic [8*KEY_CHARS-1:0] sh;
        sh = key << (8 * pos);
        key_hit = (pos < len) && (to_lower(c) == sh[8*KEY_CHARS-1 -: 8]);
    endfunction

    function automatic t_key key_feed(input t_key k, input logic [7:0] c);
        t_key r;
        r = k;
        if (!key_hit(KEY_PROXY, LEN_PROXY, k.pos, c)) r.cand[0] = 1'b0;
        if (!key_hit(KEY_CONN,  LEN_CONN,  k.pos, c)) r.cand[1] = 1'b0;
        if (!key_hit(KEY_CLEN,  LEN_CLEN,  k.pos, c)) r.cand[2] = 1'b0;
        if (!key_hit(KEY_TENC,  LEN_TENC,  k.pos, c)) r.cand[3] = 1'b0;
        if (k.pos != 5'd31) r.pos = k.pos + 5'd1;
        key_feed = r;
    endfunction

    function automatic logic [7:0] ka_char(input logic [3:0] pos);
        logic [8*12-1:0] sh;
        sh = KA_TEXT << (8 * pos);
        ka_char = sh[8*12-1 -: 8];
    endfunction

    function automatic logic [7:0] ck_char(input logic [2:0] pos);
        logic [8*7-1:0] sh;
        sh = CK_TEXT << (8 * pos);
        ck_char = sh[8*7-1 -: 8];
    endfunction

endpackage

FILE: design/hmf_len_acc.sv
// hmf_len_acc: one decimal or hex digit step of the length accumulator, with saturation
// depends on hmf_pkg
module hmf_len_acc import hmf_pkg::*; #(
    parameter int LENGTH_BITS = 48
) (
    input  logic [LENGTH_BITS-1:0] i_accum,
    input  logic [7:0]             i_byte,
    output logic [LENGTH_BITS-1:0] o_dec_val,
    output logic                   o_dec_sat,
    output logic [LENGTH_BITS-1:0] o_hex_val,
    output logic                   o_hex_sat
);
    logic [LENGTH_BITS+3:0] dec_wide;
    logic [4:0]             hex_d;

    // accum*10 + digit, overflow when any bit above the counter is set
    assign dec_wide = ({4'd0, i_accum} << 3) + ({4'd0, i_accum} << 1)
                    + {{LENGTH_BITS{1'b0}}, i_byte[3:0]};
    assign o_dec_sat = |dec_wide[LENGTH_BITS+3:LENGTH_BITS];
    assign o_dec_val = o_dec_sat ? {LENGTH_BITS{1'b1}} : dec_wide[LENGTH_BITS-1:0];

    assign hex_d     = hex_val(i_byte);
    assign o_hex_sat = |i_accum[LENGTH_BITS-1:LENGTH_BITS-4];
    assign o_hex_val = o_hex_sat ? {LENGTH_BITS{1'b1}}
                                 : {i_accum[LENGTH_BITS-5:0], hex_d[3:0]};
endmodule

FILE: design/http_message_framer_core.sv
// http_message_framer_core: byte-wide http/1.x message framer, top level
// depends on hmf_pkg and hmf_len_acc
//
// Takes one byte of an http/1.x message per word and returns the same byte tagged with
// its section (header line, blank line, body, chunk size, chunk data, chunk end,
// trailer). tlast marks the byte that completes a message; tuser bit 3 (conn_reuse)
// then carries the reuse flag. All header matching, length parsing and counting happen
// in one pass between the accepted byte and the output register, and a new word is
// taken each cycle as long as the output register is empty or being drained in the
// same cycle. Output valid rises in the cycle after the accept.
// Lengths are LENGTH_BITS wide and saturate at all ones.
module http_message_framer_core import hmf_pkg::*; #(
    parameter int LENGTH_BITS = 48
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_in
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] data_out
    output logic       o_m_axis_tlast,   // message_end
    output logic [4:0] o_m_axis_tuser    // [2:0] section, [3] conn_reuse, [4] length_saturated
);
    localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;

    // parser state
    t_phase                 r_phase, n_phase;
    logic                   r_lfc, n_lfc;          // line opened with cr
    logic [1:0]             r_lbc, n_lbc;          // line byte count, sticks at 3
    t_key                   r_key, n_key;
    logic                   r_in_val, n_in_val;
    logic                   r_pcolon, n_pcolon;
    logic [3:0]             r_kpos, n_kpos;
    logic                   r_kok, n_kok;
    logic [2:0]             r_cpos, n_cpos;
    logic [2:0]             r_nps, n_nps;
    logic                   r_neg, n_neg;
    logic [LENGTH_BITS-1:0] r_accum, n_accum;
    logic [LENGTH_BITS-1:0] r_decl, n_decl;
    logic                   r_chunked, n_chunked;
    logic                   r_reuse, n_reuse;
    logic [LENGTH_BITS-1:0] r_remain, n_remain;
    logic [LENGTH_BITS-1:0] r_csize, n_csize;

    // output register
    logic                   r_ovalid;
    logic [7:0]             r_odata;
    logic [2:0]             r_osec;
    logic                   r_oend, r_oka, r_osat;

    logic [2:0]             sec;
    logic                   msg_end, ka, sat, do_clear, do_finish, accept;
    logic [LENGTH_BITS-1:0] dec_val, hex_val_acc;
    logic                   dec_sat, hex_sat;
    logic [4:0]             hd;
    logic [7:0]             c;

    assign c               = i_s_axis_tdata;
    assign o_s_axis_tready = !r_ovalid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign hd              = hex_val(c);

    hmf_len_acc #(.LENGTH_BITS(LENGTH_BITS)) u_acc (
        .i_accum   (r_accum),
        .i_byte    (c),
        .o_dec_val (dec_val),
        .o_dec_sat (dec_sat),
        .o_hex_val (hex_val_acc),
        .o_hex_sat (hex_sat)
    );

    always_comb begin
        n_phase = r_phase;  n_lfc = r_lfc;  n_lbc = r_lbc;  n_key = r_key;
        n_in_val = r_in_val;  n_pcolon = r_pcolon;  n_kpos = r_kpos;  n_kok = r_kok;
        n_cpos = r_cpos;  n_nps = r_nps;  n_neg = r_neg;  n_accum = r_accum;
        n_decl = r_decl;  n_chunked = r_chunked;  n_reuse = r_reuse;
        n_remain = r_remain;  n_csize = r_csize;
        sec = SEC_HEADER;  msg_end = 1'b0;  ka = 1'b0;  sat = 1'b0;
        do_clear = 1'b0;  do_finish = 1'b0;

        case (r_phase)
            PH_BODY: begin
                sec = SEC_BODY;
                if (r_remain != LEN_ZERO) n_remain = r_remain - 1'b1;
                if (n_remain == LEN_ZERO) begin
                    if (r_chunked) begin
                        n_phase = PH_CSIZE;
                        do_clear = 1'b1;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
            PH_CSIZE: begin
                sec = SEC_CSIZE;
                if (c == CH_LF) begin
                    if (r_nps >= NP_ZERO && r_nps <= NP_END) n_csize = r_accum;
                    do_clear = 1'b1;
                    n_phase = (n_csize != LEN_ZERO) ? PH_CDATA : PH_TRAILER;
                end else begin
                    case (r_nps)
                        NP_IDLE: begin
                            if (!is_blank(c)) begin
                                if (c == CH_ZERO) begin
                                    n_accum = LEN_ZERO;
                                    n_nps = NP_ZERO;
                                end else if (!hd[4]) begin
                                    n_accum = hex_val_acc;  sat = hex_sat;
                                    n_nps = NP_DIGITS;
                                end else begin
                                    n_nps = NP_BAD;
                                end
                            end
                        end
                        NP_ZERO: begin
                            if (c == CH_LX || c == CH_UX) n_nps = NP_PFX;
                            else if (!hd[4]) begin
                                n_accum = hex_val_acc;  sat = hex_sat;
                                n_nps = NP_DIGITS;
                            end else n_nps = NP_END;
                        end
                        NP_PFX, NP_DIGITS: begin
                            if (!hd[4]) begin
                                n_accum = hex_val_acc;  sat = hex_sat;
                                n_nps = NP_DIGITS;
                            end else n_nps = NP_END;
                        end
                        default: ;
                    endcase
                end
            end
            PH_CDATA: begin
                sec = SEC_CDATA;
                if (r_csize != LEN_ZERO) n_csize = r_csize - 1'b1;
                if (n_csize == LEN_ZERO) n_phase = PH_CEND;
            end
            PH_CEND: begin
                sec = SEC_CEND;
                if (c == CH_LF) begin
                    n_phase = PH_CSIZE;
                    do_clear = 1'b1;
                end
            end
            PH_TRAILER: begin
                sec = SEC_TRAILER;
                if (c == CH_LF) do_finish = 1'b1;
            end
            default: begin
                n_phase = PH_HEADER;
                if (c == CH_LF && r_lbc == 2'd1 && r_lfc) begin
                    // blank line closes the header block
                    sec = SEC_BLANK;
                    do_clear = 1'b1;
                    if (r_decl != LEN_ZERO) begin
                        n_remain = r_decl;
                        n_phase = PH_BODY;
                    end else if (r_chunked) begin
                        n_phase = PH_CSIZE;
                    end else begin
                        do_finish = 1'b1;
                    end
                end else begin
                    sec = (r_lbc == 2'd0 && c == CH_CR) ? SEC_BLANK : SEC_HEADER;
                    if (r_lbc == 2'd0) n_lfc = (c == CH_CR);
                    if (r_lbc != 2'd3) n_lbc = r_lbc + 2'd1;
                    if (r_in_val) begin
                        // keep-alive must match the whole value, any case
                        if (r_kok && r_kpos < KA_LEN && to_lower(c) == ka_char(r_kpos))
                            n_kpos = r_kpos + 4'd1;
                        else
                            n_kok = 1'b0;
                        if (r_cpos < CK_LEN) begin
                            if (c == ck_char(r_cpos)) n_cpos = r_cpos + 3'd1;
                            else n_cpos = (c == CH_LC) ? 3'd1 : 3'd0;
                        end
                        // content-length value, atoll style
                        if (r_key.cand[2]) begin
                            if (r_nps == NP_IDLE) begin
                                if (is_blank(c) || c == CH_LF) begin
                                    n_nps = NP_IDLE;
                                end else if (c == CH_MINUS) begin
                                    n_neg = 1'b1;  n_nps = NP_ZERO;
                                end else if (c == CH_PLUS) begin
                                    n_nps = NP_ZERO;
                                end else if (hd[4] || c > 8'h39) begin
                                    n_nps = NP_PFX;
                                end else begin
                                    n_accum = dec_val;  sat = dec_sat;  n_nps = NP_ZERO;
                                end
                            end else if (r_nps == NP_ZERO) begin
                                if (c >= CH_ZERO && c <= 8'h39) begin
                                    n_accum = dec_val;  sat = dec_sat;
                                end else n_nps = NP_PFX;
                            end
                        end
                    end else if (r_pcolon && c == CH_SP) begin
                        n_pcolon = 1'b0;
                        n_in_val = 1'b1;
                        if (r_key.pos != LEN_PROXY) n_key.cand[0] = 1'b0;
                        if (r_key.pos != LEN_CONN)  n_key.cand[1] = 1'b0;
                        if (r_key.pos != LEN_CLEN)  n_key.cand[2] = 1'b0;
                        if (r_key.pos != LEN_TENC)  n_key.cand[3] = 1'b0;
                    end else begin
                        if (r_pcolon) begin
                            n_key = key_feed(n_key, CH_COLON);
                            n_pcolon = 1'b0;
                        end
                        if (c == CH_COLON) n_pcolon = 1'b1;
                        else n_key = key_feed(n_key, c);
                    end
                    if (c == CH_LF) begin
                        if (n_in_val) begin
                            if ((|n_key.cand[1:0]) && n_kok && n_kpos == KA_LEN)
                                n_reuse = 1'b1;
                            if (n_key.cand[2]) n_decl = n_neg ? LEN_ZERO : n_accum;
                            if (n_key.cand[3] && n_cpos == CK_LEN) n_chunked = 1'b1;
                        end
                        do_clear = 1'b1;
                    end
                end
            end
        endcase

        if (do_finish) begin
            msg_end = 1'b1;  ka = r_reuse;
            n_phase = PH_HEADER;
            n_decl = LEN_ZERO;  n_chunked = 1'b0;  n_reuse = 1'b0;
            n_remain = LEN_ZERO;  n_csize = LEN_ZERO;
        end
        if (do_clear || do_finish) begin
            n_lfc = 1'b0;  n_lbc = 2'd0;  n_key = '{cand: 4'hf, pos: 5'd0};
            n_in_val = 1'b0;  n_pcolon = 1'b0;  n_kpos = 4'd0;  n_kok = 1'b1;
            n_cpos = 3'd0;  n_nps = NP_IDLE;  n_neg = 1'b0;  n_accum = LEN_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;  r_lfc <= 1'b0;  r_lbc <= 2'd0;
            r_key <= '{cand: 4'hf, pos: 5'd0};
            r_in_val <= 1'b0;  r_pcolon <= 1'b0;  r_kpos <= 4'd0;  r_kok <= 1'b1;
            r_cpos <= 3'd0;  r_nps <= NP_IDLE;  r_neg <= 1'b0;  r_accum <= LEN_ZERO;
            r_decl <= LEN_ZERO;  r_chunked <= 1'b0;  r_reuse <= 1'b0;
            r_remain <= LEN_ZERO;  r_csize <= LEN_ZERO;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;  r_lfc <= n_lfc;  r_lbc <= n_lbc;  r_key <= n_key;
                r_in_val <= n_in_val;  r_pcolon <= n_pcolon;  r_kpos <= n_kpos;
                r_kok <= n_kok;  r_cpos <= n_cpos;  r_nps <= n_nps;  r_neg <= n_neg;
                r_accum <= n_accum;  r_decl <= n_decl;  r_chunked <= n_chunked;
                r_reuse <= n_reuse;  r_remain <= n_remain;  r_csize <= n_csize;
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_odata <= c;
            r_osec  <= sec;
            r_oend  <= msg_end;
            r_oka   <= ka;
            r_osat  <= sat;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_oend;
    assign o_m_axis_tuser  = {r_osat, r_oka, r_osec};

    // a message ends only on a blank line, a body byte or a trailer byte
    a_end_section: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |->
            (r_osec == SEC_BLANK || r_osec == SEC_BODY || r_osec == SEC_TRAILER))
        else $error("message end outside a closing section");

    // keep-alive is only reported with the message end
    a_ka_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_oka |-> o_m_axis_tlast)
        else $error("conn_reuse without message end");

    // saturation comes only from a header value or a chunk size digit
    a_sat_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_osat |-> (r_osec == SEC_HEADER || r_osec == SEC_CSIZE))
        else $error("saturation flag in wrong section");

    // chunk data never runs with a zero count
    a_cdata_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CDATA |-> r_csize != LEN_ZERO)
        else $error("chunk data phase with zero size");

    // per-message state is back at reset after the message end
    a_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && do_finish |=> (r_phase == PH_HEADER && !r_reuse && !r_chunked))
        else $error("state not cleared after message end");
endmodule
